/* hw/rtl/gcs_pkg.sv */
// ----------------------------------------------------------------------------
// gcs_pkg: shared types and constants of the greedy change splitter
// Holds the field widths, the status codes, the denomination table and the
// reciprocal that the 5000 cent step uses in place of a divider.
// ----------------------------------------------------------------------------
package gcs_pkg;

    // Field widths of the item and result beats.
    localparam int AMOUNT_W = 24;
    localparam int STATUS_W = 2;
    localparam int DENOM_W  = 13;
    localparam int COUNT_W  = 12;

    // Number of denominations and the index width that addresses them.
    localparam int NUM_DENOMS = 12;
    localparam int DIDX_W     = 4;

    // Status codes of a result beat.
    localparam logic [STATUS_W-1:0] ST_CHANGE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;

    // The largest denomination is 8 * 625, so an amount is divided by 5000
    // as (amount >> 3) * floor(2^32 / 625) >> 32, which is the true quotient
    // or one below it for any 21-bit operand.
    localparam int                  BIG_SHIFT  = 3;
    localparam int                  RECIP_W    = 23;
    localparam int                  RECIP_FRAC = 32;
    localparam logic [RECIP_W-1:0]  BIG_RECIP  = 23'd6871947;
    localparam int                  PROD_W     = (AMOUNT_W - BIG_SHIFT) + RECIP_W;
    localparam logic [DENOM_W-1:0]  BIG_DENOM  = 13'd5000;

    // Denomination values in cents, largest first.
    function automatic logic [DENOM_W-1:0] denom_value(input logic [DIDX_W-1:0] idx);
        logic [DENOM_W-1:0] val;
        begin
            unique case (idx)
                4'd0:    val = 13'd5000;
                4'd1:    val = 13'd2000;
                4'd2:    val = 13'd1000;
                4'd3:    val = 13'd500;
                4'd4:    val = 13'd200;
                4'd5:    val = 13'd100;
                4'd6:    val = 13'd50;
                4'd7:    val = 13'd20;
                4'd8:    val = 13'd10;
                4'd9:    val = 13'd5;
                4'd10:   val = 13'd2;
                4'd11:   val = 13'd1;
                default: val = 13'd1;
            endcase
            return val;
        end
    endfunction

endpackage

/* hw/rtl/gcs_in_if.sv */
// ----------------------------------------------------------------------------
// gcs_in_if: item channel of the greedy change splitter
// Carries one amount due and one amount paid per beat, with valid and ready.
// ----------------------------------------------------------------------------
interface gcs_in_if;

    logic                         valid;
    logic                         ready;
    logic [gcs_pkg::AMOUNT_W-1:0] amount_due;
    logic [gcs_pkg::AMOUNT_W-1:0] amount_paid;

    modport source (output valid, output amount_due, output amount_paid, input ready);
    modport sink   (input valid, input amount_due, input amount_paid, output ready);

endinterface

/* hw/rtl/gcs_out_if.sv */
// ----------------------------------------------------------------------------
// gcs_out_if: result channel of the greedy change splitter
// Carries one status, denomination, piece count and last flag per beat.
// ----------------------------------------------------------------------------
interface gcs_out_if;

    logic                         valid;
    logic                         ready;
    logic [gcs_pkg::STATUS_W-1:0] status;
    logic [gcs_pkg::DENOM_W-1:0]  denomination;
    logic [gcs_pkg::COUNT_W-1:0]  piece_count;
    logic                         last;

    modport source (output valid, output status, output denomination,
                    output piece_count, output last, input ready);
    modport sink   (input valid, input status, input denomination,
                    input piece_count, input last, output ready);

endinterface

/* hw/rtl/greedy_change_splitter_top.sv */
// ----------------------------------------------------------------------------
// greedy_change_splitter_top: greedy change making over twelve denominations
// Splits amount_paid - amount_due over 5000 .. 1 cents, one result beat for
// each denomination with a nonzero count, driven by a small microprogram.
// ----------------------------------------------------------------------------
// The block takes one item at a time. After the item beat the microprogram
// runs one step per cycle (a step that may write a result beat first waits
// for a free output register): a check step, three steps for the 5000 cent
// denomination (reciprocal multiply, back multiply, correction) and one step
// for each smaller denomination, ending as soon as nothing is left to return.
// A short or exact payment ends at the check step. Results leave through a
// single output register, so the next item is taken while the last result
// still waits.
module greedy_change_splitter_top
(
    input  logic      clk,
    input  logic      rst_n,
    gcs_in_if.sink    item,
    gcs_out_if.source result
);

    // Microprogram operations.
    typedef enum logic [2:0]
    {
        OP_CHECK,
        OP_MUL,
        OP_QMUL,
        OP_FIX,
        OP_SMALL
    } op_t;

    // One control word: operation, denomination index, and whether the step
    // may write a result beat (and so must wait for a free output register).
    typedef struct packed
    {
        op_t                         op;
        logic [gcs_pkg::DIDX_W-1:0]  didx;
        logic                        emits;
    } ctrl_word_t;

    localparam int                         PC_W      = 4;
    localparam logic [PC_W-1:0]            LAST_STEP = 4'd14;
    localparam int                         QD_W      = gcs_pkg::COUNT_W + gcs_pkg::DENOM_W;

    // Program ROM: check, the 5000 cent sequence, then one step per smaller coin.
    function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        begin
            unique case (pc)
                4'd0:    cw = '{op: OP_CHECK, didx: 4'd0, emits: 1'b1};
                4'd1:    cw = '{op: OP_MUL,   didx: 4'd0, emits: 1'b0};
                4'd2:    cw = '{op: OP_QMUL,  didx: 4'd0, emits: 1'b0};
                4'd3:    cw = '{op: OP_FIX,   didx: 4'd0, emits: 1'b1};
                default: cw = '{op: OP_SMALL, didx: 4'(pc - 4'd3), emits: 1'b1};
            endcase
            return cw;
        end
    endfunction

    logic                              busy_reg;
    logic [PC_W-1:0]                   pc_reg;
    logic [gcs_pkg::AMOUNT_W-1:0]      rem_reg;
    logic                              short_reg;
    logic [gcs_pkg::PROD_W-1:0]        prod_reg;
    logic [gcs_pkg::COUNT_W-1:0]       quo_reg;
    logic [QD_W-1:0]                   qd_reg;

    logic                              out_valid_reg;
    logic [gcs_pkg::STATUS_W-1:0]      out_status_reg;
    logic [gcs_pkg::DENOM_W-1:0]       out_denom_reg;
    logic [gcs_pkg::COUNT_W-1:0]       out_count_reg;
    logic                              out_last_reg;

    ctrl_word_t                        cw;
    logic                              out_free;
    logic                              step_go;
    logic [gcs_pkg::AMOUNT_W:0]        diff;
    logic [QD_W-1:0]                   fix_rem;
    logic [gcs_pkg::DENOM_W-1:0]       step_denom;
    logic [gcs_pkg::DENOM_W:0]         step_denom2;

    logic                              em_valid;
    logic [gcs_pkg::STATUS_W-1:0]      em_status;
    logic [gcs_pkg::DENOM_W-1:0]       em_denom;
    logic [gcs_pkg::COUNT_W-1:0]       em_count;
    logic                              em_last;
    logic                              step_done;
    logic [gcs_pkg::AMOUNT_W-1:0]      rem_next;

    // Current control word and the handshake around the sequencer.
    assign cw       = rom_word(pc_reg);
    assign out_free = !out_valid_reg || result.ready;
    assign step_go  = busy_reg && (!cw.emits || out_free);
    assign item.ready = !busy_reg;

    // Difference with borrow, taken at the item beat.
    assign diff = {1'b0, item.amount_paid} - {1'b0, item.amount_due};

    // Datapath of the current step.
    assign fix_rem     = QD_W'(rem_reg) - qd_reg;
    assign step_denom  = gcs_pkg::denom_value(cw.didx);
    assign step_denom2 = {step_denom, 1'b0};

    always_comb
    begin
        em_valid  = 1'b0;
        em_status = gcs_pkg::ST_CHANGE;
        em_denom  = step_denom;
        em_count  = '0;
        em_last   = 1'b0;
        step_done = 1'b0;
        rem_next  = rem_reg;
        unique case (cw.op)
            OP_CHECK:
            begin
                if (short_reg || (rem_reg == '0))
                begin
                    em_valid  = 1'b1;
                    em_status = short_reg ? gcs_pkg::ST_SHORT : gcs_pkg::ST_NONE;
                    em_denom  = '0;
                    em_last   = 1'b1;
                    step_done = 1'b1;
                end
            end
            OP_FIX:
            begin
                if (fix_rem >= QD_W'(gcs_pkg::BIG_DENOM))
                begin
                    em_count = quo_reg + 1'b1;
                    rem_next = gcs_pkg::AMOUNT_W'(fix_rem - QD_W'(gcs_pkg::BIG_DENOM));
                end
                else
                begin
                    em_count = quo_reg;
                    rem_next = gcs_pkg::AMOUNT_W'(fix_rem);
                end
                em_valid  = (em_count != '0);
                em_last   = (rem_next == '0);
                step_done = (rem_next == '0);
            end
            OP_SMALL:
            begin
                // The remainder is below the previous denomination, so the
                // count here is at most two.
                if (rem_reg >= gcs_pkg::AMOUNT_W'(step_denom2))
                begin
                    em_count = gcs_pkg::COUNT_W'(2);
                    rem_next = rem_reg - gcs_pkg::AMOUNT_W'(step_denom2);
                end
                else if (rem_reg >= gcs_pkg::AMOUNT_W'(step_denom))
                begin
                    em_count = gcs_pkg::COUNT_W'(1);
                    rem_next = rem_reg - gcs_pkg::AMOUNT_W'(step_denom);
                end
                em_valid  = (em_count != '0);
                em_last   = (rem_next == '0);
                step_done = (rem_next == '0) || (pc_reg == LAST_STEP);
            end
            default:
            begin
                step_done = 1'b0;
            end
        endcase
    end

    // Sequencer, datapath registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                busy_reg  <= 1'b1;
                pc_reg    <= '0;
                rem_reg   <= diff[gcs_pkg::AMOUNT_W-1:0];
                short_reg <= diff[gcs_pkg::AMOUNT_W];
            end
            else if (step_go)
            begin
                if (cw.op == OP_MUL)
                begin
                    prod_reg <= rem_reg[gcs_pkg::AMOUNT_W-1:gcs_pkg::BIG_SHIFT]
                                * gcs_pkg::BIG_RECIP;
                end
                if (cw.op == OP_QMUL)
                begin
                    quo_reg <= prod_reg[gcs_pkg::PROD_W-1:gcs_pkg::RECIP_FRAC];
                    qd_reg  <= prod_reg[gcs_pkg::PROD_W-1:gcs_pkg::RECIP_FRAC]
                               * gcs_pkg::BIG_DENOM;
                end
                rem_reg <= rem_next;
                if (step_done)
                begin
                    busy_reg <= 1'b0;
                    pc_reg   <= '0;
                end
                else
                begin
                    pc_reg <= pc_reg + 1'b1;
                end
            end

            // A new result beat overrides the one the sink just took.
            if (step_go && em_valid)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= em_status;
                out_denom_reg  <= em_denom;
                out_count_reg  <= em_count;
                out_last_reg   <= em_last;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.denomination = out_denom_reg;
    assign result.piece_count  = out_count_reg;
    assign result.last         = out_last_reg;

`ifndef SYNTHESIS
    // A status beat carries no denomination and closes its item.
    a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != gcs_pkg::ST_CHANGE))
        |-> (result.denomination == '0) && result.last)
        else $error("status beat with denomination or without last");

    // A change beat never carries a zero count.
    a_change_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == gcs_pkg::ST_CHANGE)) |-> (result.piece_count != '0))
        else $error("change beat with zero piece count");

    // While a non-final beat waits, the sequencer still owns that item.
    a_open_item: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.last) |-> busy_reg)
        else $error("sequencer idle before the last beat of an item");

    // The step counter never runs past the end of the program.
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= LAST_STEP)
        else $error("step counter beyond the program");

    // An item beat starts the program at its first step.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> (busy_reg && (pc_reg == '0)))
        else $error("item beat did not start the program");
`endif

endmodule

/* tb/tb_greedy_change_splitter_top.sv */
// ----------------------------------------------------------------------------
// tb_greedy_change_splitter_top: self-checking bench of the change splitter
// Drives amount pairs into the item channel and checks every result beat
// against a behavioral model of greedy change making over the twelve euro
// denominations, or the beat of a typed directed row. The short directed
// table leads, then random pairs with random item idles and result stalls.
// ----------------------------------------------------------------------------
module tb_greedy_change_splitter_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [gcs_pkg::AMOUNT_W-1:0] amount_t;

    localparam amount_t AMOUNT_MAX    = {gcs_pkg::AMOUNT_W{1'b1}};
    localparam int      RANDOM_ITEMS  = 360;
    localparam int      DIRECTED_ROWS = 20;
    localparam int      DRAIN_CYCLES  = 24;
    localparam int      IDLE_PCT      = 7;

    // Coin and note values in cents, largest first.
    localparam int unsigned CENT_VALUES [gcs_pkg::NUM_DENOMS] =
        '{5000, 2000, 1000, 500, 200, 100, 50, 20, 10, 5, 2, 1};

    typedef struct packed {
        logic [gcs_pkg::STATUS_W-1:0] status;
        logic [gcs_pkg::DENOM_W-1:0]  denom;
        logic [gcs_pkg::COUNT_W-1:0]  count;
        logic                         last;
    } change_beat_t;

    typedef struct {
        amount_t      due;
        amount_t      paid;
        bit           typed;
        change_beat_t beat;
    } stim_row_t;

    logic clk;
    logic rst_n;

    gcs_in_if  item_ch ();
    gcs_out_if result_ch ();

    greedy_change_splitter_top DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    change_beat_t change_due_q [$];
    int           mismatch_count;
    bit           steady;
    bit           row_typed;
    change_beat_t row_beat;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #2_000_000;
        $display("tb_greedy_change_splitter_top: FAIL");
        $finish;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Greedy split of paid - due into the change beats it should produce.
    function automatic void split_change(input amount_t due, input amount_t paid);
        int unsigned  left;
        int unsigned  pieces;
        change_beat_t beat;
        if (paid < due)
        begin
            beat = '{status: gcs_pkg::ST_SHORT, denom: '0, count: '0, last: 1'b1};
            change_due_q.push_back(beat);
        end
        else if (paid == due)
        begin
            beat = '{status: gcs_pkg::ST_NONE, denom: '0, count: '0, last: 1'b1};
            change_due_q.push_back(beat);
        end
        else
        begin
            left = 32'(paid - due);
            for (int i = 0; i < gcs_pkg::NUM_DENOMS; i++)
            begin
                pieces = left / CENT_VALUES[i];
                if (pieces != 0)
                begin
                    left -= pieces * CENT_VALUES[i];
                    beat.status = gcs_pkg::ST_CHANGE;
                    beat.denom  = CENT_VALUES[i][gcs_pkg::DENOM_W-1:0];
                    beat.count  = pieces[gcs_pkg::COUNT_W-1:0];
                    beat.last   = (left == 0);
                    change_due_q.push_back(beat);
                end
            end
        end
    endfunction

    // Result side stalls at random, except during the steady stretch.
    always @(negedge clk)
    begin
        result_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Checks result beats first, then records the expectations of an item beat.
    always @(posedge clk)
    begin : watch
        change_beat_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (change_due_q.size() == 0)
                begin
                    report_mismatch("unexpected result beat", 32'(result_ch.status), 0);
                end
                else
                begin
                    want = change_due_q.pop_front();
                    if (result_ch.status !== want.status)
                        report_mismatch("status", 32'(result_ch.status),
                                        32'(want.status));
                    if (result_ch.denomination !== want.denom)
                        report_mismatch("denomination", 32'(result_ch.denomination),
                                        32'(want.denom));
                    if (result_ch.piece_count !== want.count)
                        report_mismatch("piece_count", 32'(result_ch.piece_count),
                                        32'(want.count));
                    if (result_ch.last !== want.last)
                        report_mismatch("last", 32'(result_ch.last), 32'(want.last));
                end
            end
            if (item_ch.valid && item_ch.ready)
            begin
                if (row_typed)
                    change_due_q.push_back(row_beat);
                else
                    split_change(item_ch.amount_due, item_ch.amount_paid);
            end
        end
    end

    // Sends one item beat, with random idle cycles ahead of it. Starts and
    // returns just after a falling edge.
    task automatic send_item(input amount_t due, input amount_t paid,
                             input bit typed, input change_beat_t beat);
        bit taken;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.amount_due  <= due;
        item_ch.amount_paid <= paid;
        row_typed = typed;
        row_beat  = beat;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = item_ch.ready;
        end
        @(negedge clk);
    endtask

    // Random amount pair, weighted toward change that walks the small coins.
    task automatic make_pair(output amount_t due, output amount_t paid);
        int unsigned pick;
        int unsigned diff;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            due  = amount_t'($urandom_range(AMOUNT_MAX, 0));
            paid = due;
        end
        else if (pick < 20)
        begin
            paid = amount_t'($urandom_range(AMOUNT_MAX - 24'd1, 0));
            due  = amount_t'($urandom_range(AMOUNT_MAX, paid + 1));
        end
        else if (pick < 35)
        begin
            due  = amount_t'($urandom_range(AMOUNT_MAX, 0));
            paid = amount_t'($urandom_range(AMOUNT_MAX, 0));
        end
        else
        begin
            if (pick < 55)
                diff = $urandom_range(9999, 1);
            else if (pick < 75)
                diff = $urandom_range(99, 1);
            else
                diff = $urandom_range(AMOUNT_MAX, 1);
            due  = amount_t'($urandom_range(AMOUNT_MAX - diff, 0));
            paid = amount_t'(due + diff);
        end
    endtask

    // Directed table: extremes, both special statuses and every denomination.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{24'd0,       24'd0,         1'b1, '{gcs_pkg::ST_NONE,   13'd0,    12'd0, 1'b1}},
        '{AMOUNT_MAX,  AMOUNT_MAX,    1'b1, '{gcs_pkg::ST_NONE,   13'd0,    12'd0, 1'b1}},
        '{24'd1,       24'd0,         1'b1, '{gcs_pkg::ST_SHORT,  13'd0,    12'd0, 1'b1}},
        '{AMOUNT_MAX,  24'd0,         1'b1, '{gcs_pkg::ST_SHORT,  13'd0,    12'd0, 1'b1}},
        '{AMOUNT_MAX,  AMOUNT_MAX - 24'd1,
                                      1'b1, '{gcs_pkg::ST_SHORT,  13'd0,    12'd0, 1'b1}},
        '{24'hAAAAAA,  24'h555555,    1'b1, '{gcs_pkg::ST_SHORT,  13'd0,    12'd0, 1'b1}},
        '{24'd0,       24'd1,         1'b1, '{gcs_pkg::ST_CHANGE, 13'd1,    12'd1, 1'b1}},
        '{24'd0,       24'd5000,      1'b1, '{gcs_pkg::ST_CHANGE, 13'd5000, 12'd1, 1'b1}},
        '{24'd800000,  24'd800002,    1'b1, '{gcs_pkg::ST_CHANGE, 13'd2,    12'd1, 1'b1}},
        '{24'd300,     24'd340,       1'b1, '{gcs_pkg::ST_CHANGE, 13'd20,   12'd2, 1'b1}},
        '{24'd0,       AMOUNT_MAX,    1'b0, '{gcs_pkg::ST_CHANGE, 13'd0,    12'd0, 1'b0}},
        '{AMOUNT_MAX - 24'd1, AMOUNT_MAX,
                                      1'b0, '{gcs_pkg::ST_CHANGE, 13'd0,    12'd0, 1'b0}},
        '{24'd1,       24'd8889,      1'b0, '{gcs_pkg::ST_CHANGE, 13'd0,    12'd0, 1'b0}},
        '{24'd100,     24'd5099,      1'b0, '{gcs_pkg::ST_CHANGE, 13'd0,    12'd0, 1'b0}},
        '{24'd0,       24'd9999,      1'b0, '{gcs_pkg::ST_CHANGE, 13'd0,    12'd0, 1'b0}},
        '{24'd12345,   24'd12348,     1'b0, '{gcs_pkg::ST_CHANGE, 13'd0,    12'd0, 1'b0}},
        '{24'h555555,  24'hAAAAAA,    1'b0, '{gcs_pkg::ST_CHANGE, 13'd0,    12'd0, 1'b0}},
        '{24'd0,       24'd4999,      1'b0, '{gcs_pkg::ST_CHANGE, 13'd0,    12'd0, 1'b0}},
        '{24'd7,       24'd10007,     1'b0, '{gcs_pkg::ST_CHANGE, 13'd0,    12'd0, 1'b0}},
        '{24'd0,       24'd16775000,  1'b0, '{gcs_pkg::ST_CHANGE, 13'd0,    12'd0, 1'b0}}
    };

    // Main stimulus.
    initial
    begin
        amount_t      due;
        amount_t      paid;
        change_beat_t no_beat;
        no_beat                 = '0;
        mismatch_count          = 0;
        steady                  = 1'b0;
        row_typed               = 1'b0;
        row_beat                = '0;
        item_ch.valid           = 1'b0;
        item_ch.amount_due      = '0;
        item_ch.amount_paid     = '0;
        rst_n                   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].due, directed_rows[i].paid,
                      directed_rows[i].typed, directed_rows[i].beat);

        // Random pairs, with a long stretch that never idles or stalls.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 120) && (i < 220);
            make_pair(due, paid);
            send_item(due, paid, 1'b0, no_beat);
        end
        steady = 1'b0;
        item_ch.valid <= 1'b0;

        while (change_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_greedy_change_splitter_top: PASS");
        else
            $display("tb_greedy_change_splitter_top: FAIL");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/gcs_pkg.sv
hw/rtl/gcs_in_if.sv
hw/rtl/gcs_out_if.sv
hw/rtl/greedy_change_splitter_top.sv
tb/tb_greedy_change_splitter_top.sv
